// File: design/fpwm_pkg.sv
package fpwm_pkg;

	// Field widths fixed by the interface.
	localparam int TEMP_W      = 18;
	localparam int PWM_W       = 8;
	localparam int SPEED_W     = 16;
	localparam int WLEN_W      = 5;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 8;
	localparam int S_TDATA_W   = 48;
	localparam int M_TDATA_W   = 8;

	// Divisor width covers the temperature span (at most 255000) and any fill count.
	localparam int DEN_W       = 18;
	// Magnitude of the interpolation product stays below 2**26.
	localparam int PROD_MAG_W  = 26;
	localparam int PROD_W      = 28;

	localparam int MILLI_PER_DEG = 1000;
	localparam int PWM_CEIL      = 255;

	localparam int MAX_WINDOW_DEF = 16;

	// Register reset values.
	localparam logic [7:0] LOW_TEMP_RST   = 8'd40;
	localparam logic [7:0] HIGH_TEMP_RST  = 8'd80;
	localparam logic [7:0] START_PWM_RST  = 8'd150;
	localparam logic [7:0] STOP_PWM_RST   = 8'd100;
	localparam logic [7:0] MIN_PWM_RST    = 8'd0;
	localparam logic [7:0] MAX_PWM_RST    = 8'd255;
	localparam logic [4:0] WINDOW_LEN_RST = 5'd1;

	// Register indexes on the configuration channel.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOW_TEMP   = 3'd0,
		CFG_HIGH_TEMP  = 3'd1,
		CFG_START_PWM  = 3'd2,
		CFG_STOP_PWM   = 3'd3,
		CFG_MIN_PWM    = 3'd4,
		CFG_MAX_PWM    = 3'd5,
		CFG_WINDOW_LEN = 3'd6
	} cfg_idx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic rd;
		logic div_start;
		logic div_sel_int;
		logic avg_take;
		logic mul_take;
		logic res_take;
		logic out_load;
		logic out_kick;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic rd_last;
		logic div_busy;
		logic div_done;
		logic mid;
		logic kick_need;
	} ctrl_status_t;

endpackage

// File: design/fan_pwm_temperature_curve.sv
// Fan PWM from temperature: each input transfer is one control tick carrying a temperature in
// millidegrees, the PWM currently applied and, when s_tuser flags fans, the slowest tachometer
// reading. The block averages the last window_len samples (window_len held within one and the
// history depth; fewer while the history fills), truncating toward zero, maps the average onto
// a linear curve between low_temp_c and high_temp_c and returns one result, or two when a
// stopped fan in the linear region first needs the start_pwm kick (m_tuser high, m_tlast low
// on the kick). One tick is handled at a time. The summation reads one history entry a cycle;
// the average then costs one pass of the shared bit-serial divider, 26 bits wide at the default
// depth of 16, and the interpolation a second pass, which a tick at the curve ends skips. A
// result waiting for m_tready holds the block. The next tick is taken as soon as the final
// result sits in the output register. Configuration writes are always ready and must only be
// made while the block is idle.
module fan_pwm_temperature_curve #(
	parameter int MAX_WINDOW = fpwm_pkg::MAX_WINDOW_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input stream.
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [17:0] temperature_mc, [25:18] previous_pwm, [41:26] min_fan_speed, [47:42] zero
	input  logic [fpwm_pkg::S_TDATA_W-1:0]       s_tdata,
	// [0] fans_present
	input  logic [0:0]                           s_tuser,
	// Result stream.
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [7:0] pwm_value
	output logic [fpwm_pkg::M_TDATA_W-1:0]       m_tdata,
	// [0] kick_start
	output logic [0:0]                           m_tuser,
	output logic                                 m_tlast,
	// Configuration write channel.
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fpwm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fpwm_pkg::CFG_DATA_W-1:0]      cfg_data
);

	fpwm_pkg::ctrl_cmd_t    cmd;
	fpwm_pkg::ctrl_status_t status;
	logic                   out_kick;

	assign cfg_ready = 1'b1;

	fpwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	fpwm_datapath #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_temp      (s_tdata[17:0]),
		.in_prev_pwm  (s_tdata[25:18]),
		.in_fans      (s_tuser[0]),
		.in_min_speed (s_tdata[41:26]),
		.out_pwm      (m_tdata),
		.out_kick     (out_kick)
	);

	// The kick is never the last result of a tick.
	assign m_tuser = out_kick;
	assign m_tlast = !out_kick;

endmodule

// File: design/fpwm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module fpwm_div #(
	parameter int NUM_W = 26,
	parameter int DEN_W = 18
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] work_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] divisor_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   rem_sh;
	logic             ge;
	logic [DEN_W:0]   rem_diff;

	// One shift-and-subtract step.
	assign rem_sh   = {rem_q, work_q[NUM_W-1]};
	assign ge       = rem_sh >= {1'b0, divisor_q};
	assign rem_diff = rem_sh - {1'b0, divisor_q};

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			work_q    <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[NUM_W-2:0], ge};
			rem_q  <= ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = work_q;

endmodule

// File: design/fpwm_datapath.sv
// Datapath: configuration registers, sample history, averaging, curve and output register.
module fpwm_datapath #(
	parameter int MAX_WINDOW = fpwm_pkg::MAX_WINDOW_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fpwm_pkg::ctrl_cmd_t                  cmd,
	output fpwm_pkg::ctrl_status_t               status,
	input  logic                                 cfg_we,
	input  logic [fpwm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fpwm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [fpwm_pkg::TEMP_W-1:0]          in_temp,
	input  logic [fpwm_pkg::PWM_W-1:0]           in_prev_pwm,
	input  logic                                 in_fans,
	input  logic [fpwm_pkg::SPEED_W-1:0]         in_min_speed,
	output logic [fpwm_pkg::PWM_W-1:0]           out_pwm,
	output logic                                 out_kick
);

	localparam int TW     = fpwm_pkg::TEMP_W;
	localparam int PW     = fpwm_pkg::PWM_W;
	localparam int AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int FILL_W = $clog2(MAX_WINDOW + 1);
	localparam int CMP_W  = (FILL_W > fpwm_pkg::WLEN_W) ? FILL_W : fpwm_pkg::WLEN_W;
	localparam int SUM_W  = TW + $clog2(MAX_WINDOW);
	localparam int NUM_W  = (SUM_W > fpwm_pkg::PROD_MAG_W) ? SUM_W : fpwm_pkg::PROD_MAG_W;
	localparam int DEN_W  = fpwm_pkg::DEN_W;
	localparam int PRW    = fpwm_pkg::PROD_W;
	localparam logic signed [TW-1:0] TEMP_SCALE = TW'(fpwm_pkg::MILLI_PER_DEG);
	localparam logic [AW-1:0] WRAP_IDX = AW'(MAX_WINDOW - 1);

	// Configuration registers.
	logic [7:0]                low_temp_q;
	logic [7:0]                high_temp_q;
	logic [PW-1:0]             start_pwm_q;
	logic [PW-1:0]             stop_pwm_q;
	logic [PW-1:0]             min_pwm_q;
	logic [PW-1:0]             max_pwm_q;
	logic [fpwm_pkg::WLEN_W-1:0] window_len_q;

	// Item and window state.
	logic [PW-1:0]             prev_pwm_q;
	logic                      fans_q;
	logic [fpwm_pkg::SPEED_W-1:0] min_speed_q;
	logic [AW-1:0]             wp_q;
	logic [FILL_W-1:0]         fill_q;
	logic [AW-1:0]             rd_idx_q;
	logic [FILL_W-1:0]         rd_cnt_q;
	logic                      acc_s1;
	logic signed [TW-1:0]      rd_data_s1;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [TW-1:0]      avg_q;
	logic signed [PRW-1:0]     prod_q;
	logic [PW-1:0]             pwm_q;
	logic [PW-1:0]             out_pwm_q;
	logic                      out_kick_q;

	logic [TW-1:0]             hist_mem [MAX_WINDOW];

	// Combinational signals.
	logic [CMP_W-1:0]          win_ext;
	logic [FILL_W-1:0]         win;
	logic [FILL_W:0]           fill_inc;
	logic [FILL_W-1:0]         fill_next;
	logic [AW-1:0]             wp_next;
	logic [AW-1:0]             rd_idx_next;
	logic signed [TW-1:0]      min_t;
	logic signed [TW-1:0]      max_t;
	logic signed [TW:0]        diff_c;
	logic signed [TW:0]        span_c;
	logic signed [PW:0]        delta_c;
	logic signed [PRW-1:0]     prod_c;
	logic                      le_min;
	logic                      ge_max;
	logic                      mid;
	logic [SUM_W-1:0]          sum_mag;
	logic [PRW-1:0]            prod_mag;
	logic [NUM_W-1:0]          div_num;
	logic [DEN_W-1:0]          div_den;
	logic                      div_busy;
	logic                      div_done;
	logic [NUM_W-1:0]          quot;
	logic [TW-1:0]             avg_pos;
	logic signed [PW+2:0]      interp_c;
	logic [PW-1:0]             interp_clamped;

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_temp_q   <= fpwm_pkg::LOW_TEMP_RST;
			high_temp_q  <= fpwm_pkg::HIGH_TEMP_RST;
			start_pwm_q  <= fpwm_pkg::START_PWM_RST;
			stop_pwm_q   <= fpwm_pkg::STOP_PWM_RST;
			min_pwm_q    <= fpwm_pkg::MIN_PWM_RST;
			max_pwm_q    <= fpwm_pkg::MAX_PWM_RST;
			window_len_q <= fpwm_pkg::WINDOW_LEN_RST;
		end else if (cfg_we) begin
			case (fpwm_pkg::cfg_idx_t'(cfg_index))
				fpwm_pkg::CFG_LOW_TEMP:   low_temp_q   <= cfg_data;
				fpwm_pkg::CFG_HIGH_TEMP:  high_temp_q  <= cfg_data;
				fpwm_pkg::CFG_START_PWM:  start_pwm_q  <= cfg_data;
				fpwm_pkg::CFG_STOP_PWM:   stop_pwm_q   <= cfg_data;
				fpwm_pkg::CFG_MIN_PWM:    min_pwm_q    <= cfg_data;
				fpwm_pkg::CFG_MAX_PWM:    max_pwm_q    <= cfg_data;
				fpwm_pkg::CFG_WINDOW_LEN: window_len_q <= cfg_data[fpwm_pkg::WLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective window length, held within one and the history depth.
	always_comb begin
		win_ext = CMP_W'(window_len_q);
		if (win_ext == '0) begin
			win_ext = CMP_W'(1);
		end else if (win_ext > CMP_W'(MAX_WINDOW)) begin
			win_ext = CMP_W'(MAX_WINDOW);
		end
		win = win_ext[FILL_W-1:0];
	end

	// Fill count and circular pointers.
	assign fill_inc    = {1'b0, fill_q} + (FILL_W + 1)'(1);
	assign fill_next   = (fill_inc > {1'b0, win}) ? win : fill_inc[FILL_W-1:0];
	assign wp_next     = (wp_q == WRAP_IDX) ? '0 : wp_q + AW'(1);
	assign rd_idx_next = (rd_idx_q == '0) ? WRAP_IDX : rd_idx_q - AW'(1);

	// Window bookkeeping and the running sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			fill_q   <= '0;
			rd_idx_q <= '0;
			rd_cnt_q <= '0;
			acc_s1   <= 1'b0;
		end else begin
			acc_s1 <= cmd.rd;
			if (cmd.load) begin
				wp_q     <= wp_next;
				fill_q   <= fill_next;
				rd_idx_q <= wp_q;
				rd_cnt_q <= '0;
			end else if (cmd.rd) begin
				rd_idx_q <= rd_idx_next;
				rd_cnt_q <= rd_cnt_q + FILL_W'(1);
			end
		end
	end

	// Sample history; only entries within the fill count are ever summed.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hist_mem[wp_q] <= in_temp;
		end
		rd_data_s1 <= hist_mem[rd_idx_q];
	end

	// Item capture and arithmetic results.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			prev_pwm_q  <= in_prev_pwm;
			fans_q      <= in_fans;
			min_speed_q <= in_min_speed;
			sum_q       <= '0;
		end else if (acc_s1) begin
			sum_q <= sum_q + SUM_W'(rd_data_s1);
		end
		if (cmd.avg_take) begin
			avg_q <= sum_q[SUM_W-1] ? TW'(-avg_pos) : avg_pos;
		end
		if (cmd.mul_take) begin
			prod_q <= prod_c;
		end
		if (cmd.res_take) begin
			pwm_q <= mid ? interp_clamped : (le_min ? min_pwm_q : max_pwm_q);
		end
		if (cmd.out_load) begin
			out_pwm_q  <= cmd.out_kick ? start_pwm_q : pwm_q;
			out_kick_q <= cmd.out_kick;
		end
	end

	// Temperature limits in millidegrees and the curve regions.
	assign min_t   = TW'(TW'(signed'(low_temp_q)) * TEMP_SCALE);
	assign max_t   = TW'(TW'(signed'(high_temp_q)) * TEMP_SCALE);
	assign le_min  = avg_q <= min_t;
	assign ge_max  = avg_q >= max_t;
	assign mid     = !le_min && !ge_max;
	assign diff_c  = (TW + 1)'(avg_q) - (TW + 1)'(min_t);
	assign span_c  = (TW + 1)'(max_t) - (TW + 1)'(min_t);
	assign delta_c = signed'({1'b0, max_pwm_q}) - signed'({1'b0, stop_pwm_q});
	assign prod_c  = PRW'(diff_c) * PRW'(delta_c);

	// Operand selection for the shared divider, as magnitudes.
	assign sum_mag  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign prod_mag = prod_q[PRW-1] ? PRW'(-prod_q) : PRW'(prod_q);
	assign div_num  = cmd.div_sel_int ? NUM_W'(prod_mag[fpwm_pkg::PROD_MAG_W-1:0])
	                                  : NUM_W'(sum_mag);
	assign div_den  = cmd.div_sel_int ? span_c[DEN_W-1:0] : DEN_W'(fill_q);

	fpwm_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quot)
	);

	// Signed results of the two divisions; the interpolation share is at most 255.
	assign avg_pos  = quot[TW-1:0];
	assign interp_c = (prod_q[PRW-1] ? -signed'({3'b000, quot[PW-1:0]})
	                                 : signed'({3'b000, quot[PW-1:0]}))
	                  + signed'({3'b000, stop_pwm_q});

	// Clamp to the PWM range.
	always_comb begin
		if (interp_c < 0) begin
			interp_clamped = '0;
		end else if (interp_c > (PW + 3)'(fpwm_pkg::PWM_CEIL)) begin
			interp_clamped = PW'(fpwm_pkg::PWM_CEIL);
		end else begin
			interp_clamped = interp_c[PW-1:0];
		end
	end

	assign status.rd_last   = rd_cnt_q == (fill_q - FILL_W'(1));
	assign status.div_busy  = div_busy;
	assign status.div_done  = div_done;
	assign status.mid       = mid;
	assign status.kick_need = mid && ((prev_pwm_q == '0) ||
	                                  (fans_q && (min_speed_q == '0)));

	assign out_pwm  = out_pwm_q;
	assign out_kick = out_kick_q;

	// The fill count never exceeds the history depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(MAX_WINDOW))
		else $error("fill count beyond history depth");

	// A division is never started while one is running.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("divider restarted while busy");

	// After an item is taken the window holds at least one sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> fill_q != '0)
		else $error("empty window after a new sample");

endmodule

// File: design/fpwm_ctrl.sv
// Controller: sequences summation, the averaging division, the interpolation division when needed, and result delivery.
module fpwm_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	input  fpwm_pkg::ctrl_status_t status,
	output fpwm_pkg::ctrl_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_SUM_END,
		ST_AVG_START,
		ST_AVG_WAIT,
		ST_MUL,
		ST_REGION,
		ST_INT_WAIT,
		ST_KICK,
		ST_FINAL
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = out_valid_q;

	// Commands and next state.
	always_comb begin
		cmd        = '0;
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load   = 1'b1;
					state_next = ST_SUM;
				end
			end
			ST_SUM: begin
				cmd.rd = 1'b1;
				if (status.rd_last) begin
					state_next = ST_SUM_END;
				end
			end
			ST_SUM_END: begin
				state_next = ST_AVG_START;
			end
			ST_AVG_START: begin
				cmd.div_start = 1'b1;
				state_next    = ST_AVG_WAIT;
			end
			ST_AVG_WAIT: begin
				if (status.div_done) begin
					cmd.avg_take = 1'b1;
					state_next   = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_take = 1'b1;
				state_next   = ST_REGION;
			end
			ST_REGION: begin
				if (status.mid) begin
					cmd.div_start   = 1'b1;
					cmd.div_sel_int = 1'b1;
					state_next      = ST_INT_WAIT;
				end else begin
					cmd.res_take = 1'b1;
					state_next   = ST_FINAL;
				end
			end
			ST_INT_WAIT: begin
				if (status.div_done) begin
					cmd.res_take = 1'b1;
					state_next   = status.kick_need ? ST_KICK : ST_FINAL;
				end
			end
			ST_KICK: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kick = 1'b1;
					state_next   = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// State and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A result is never loaded over one that has not been transferred.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || m_tready))
		else $error("output register overwritten");

	// A kick result is always followed by the final result of the same tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && cmd.out_kick) |=> state_q == ST_FINAL)
		else $error("kick not followed by final result");

	// The divider only reports completion while the controller waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> (state_q == ST_AVG_WAIT || state_q == ST_INT_WAIT))
		else $error("divider completion outside a wait state");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import fpwm_pkg::*;

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 9;
	localparam int RANDOM_TICKS  = 1400;
	localparam int HISTORY_DEPTH = MAX_WINDOW_DEF;
	localparam int SETTLE_CYCLES = 100;
	localparam int TAIL_CYCLES   = 200;
	localparam int PRINT_CAP     = 100;
	localparam int SAMPLE_MIN    = -131072;
	localparam int SAMPLE_MAX    = 131071;
	localparam int PREV_LSB      = TEMP_W;
	localparam int SPEED_LSB     = TEMP_W + PWM_W;
	localparam longint WATCHDOG_NS = 64'd20_000_000;

	typedef struct packed {
		logic [PWM_W-1:0] pwm;
		logic             kick;
		logic             last;
	} pwm_result_t;

	// One row of the directed table: a curve set to load first (or -1), the tick itself, and
	// optionally a final PWM value that can be read straight off the curve.
	typedef struct {
		int cfg_sel;
		int temp;
		int prev;
		bit fans;
		int speed;
		bit fixed;
		int pwm;
	} tick_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata = '0;
	logic [0:0]             s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic [0:0]             m_tuser;
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = CFG_LOW_TEMP;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// Travels beside each input transfer so that a typed-in result is known on acceptance.
	logic                   row_fixed = 1'b0;
	logic [PWM_W-1:0]       row_pwm = '0;

	bit                     tx_calm = 1'b0;
	bit                     rx_calm = 1'b0;
	int                     stall_left = 0;
	int                     fault_count = 0;

	// Predictor state: temperature history, curve registers and results still owed.
	logic signed [TEMP_W-1:0] temp_log [HISTORY_DEPTH];
	int                       log_pos = 0;
	int                       log_fill = 0;
	logic [7:0]               curve_reg [7];
	logic [7:0]               next_curve [7];
	pwm_result_t              pwm_due [$];

	// Curve sets of the directed part, in register order: low, high, start, stop, min, max,
	// window.
	logic [7:0] curve_sets [3][7] = '{
		'{8'd50, 8'd20, 8'd0, 8'd200, 8'd7, 8'd3, 8'd0},
		'{8'hF6, 8'd30, 8'hAA, 8'd250, 8'hFF, 8'd10, 8'd31},
		'{8'h80, 8'h7F, 8'h01, 8'd0, 8'hFF, 8'hFF, 8'd2}
	};

	tick_row_t directed_rows [$] = '{
		// Default curve, window of one.
		'{-1, 0, 0, 1, 0, 1, 0},
		'{-1, 131071, 77, 1, 65535, 1, 255},
		'{-1, -131072, 255, 0, 0, 1, 0},
		'{-1, 40000, 0, 1, 0, 1, 0},
		'{-1, 80000, 0, 1, 0, 1, 255},
		'{-1, 60000, 128, 0, 0, 0, 0},
		'{-1, 60000, 0, 0, 1234, 0, 0},
		'{-1, 60000, 200, 1, 0, 0, 0},
		'{-1, 60000, 200, 1, 65535, 0, 0},
		'{-1, 40001, 1, 1, 1, 0, 0},
		'{-1, 79999, 170, 1, 43690, 0, 0},
		// Inverted temperature and PWM limits, window length zero.
		'{0, -131072, 0, 1, 0, 1, 7},
		'{-1, 0, 255, 0, 65535, 1, 7},
		'{-1, 50000, 0, 1, 0, 1, 7},
		'{-1, 50001, 0, 1, 0, 1, 3},
		'{-1, 131071, 85, 1, 21845, 1, 3},
		// Falling curve, window beyond the history depth, growing one sample a tick.
		'{1, 10000, 0, 0, 0, 0, 0},
		'{-1, 10000, 5, 1, 0, 0, 0},
		'{-1, 29999, 5, 1, 9, 0, 0},
		'{-1, -9999, 1, 1, 1, 0, 0},
		// Widest span with the window shrunk to two.
		'{2, -131072, 0, 1, 0, 0, 0},
		'{-1, 131071, 0, 1, 0, 0, 0},
		'{-1, 0, 0, 1, 0, 0, 0}
	};

	fan_pwm_temperature_curve uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	task automatic note_fault(input string what);
		if (fault_count < PRINT_CAP)
			$display("%0t ns: mismatch: %s", $realtime, what);
		fault_count++;
	endtask

	// Works out the results of one tick: moving average, curve position, optional kick.
	task automatic forecast_fan_tick(input logic signed [TEMP_W-1:0] temp,
			input logic [PWM_W-1:0] prev, input logic fans, input logic [SPEED_W-1:0] speed,
			input logic fixed, input logic [PWM_W-1:0] fixed_pwm);
		int          win;
		int          idx;
		longint      acc;
		longint      avg;
		longint      lo_mc;
		longint      hi_mc;
		longint      stop;
		longint      top;
		longint      pwm;
		pwm_result_t res;
		win = curve_reg[CFG_WINDOW_LEN][WLEN_W-1:0];
		if (win < 1)
			win = 1;
		if (win > HISTORY_DEPTH)
			win = HISTORY_DEPTH;
		temp_log[log_pos] = temp;
		log_pos = (log_pos + 1) % HISTORY_DEPTH;
		log_fill = (log_fill + 1 > win) ? win : log_fill + 1;

		// Sum the newest samples, walking backwards from the write position.
		acc = 0;
		idx = log_pos;
		for (int i = 0; i < log_fill; i++) begin
			idx = (idx == 0) ? HISTORY_DEPTH - 1 : idx - 1;
			acc += temp_log[idx];
		end
		avg = acc / log_fill;

		lo_mc = $signed(curve_reg[CFG_LOW_TEMP]);
		lo_mc = lo_mc * MILLI_PER_DEG;
		hi_mc = $signed(curve_reg[CFG_HIGH_TEMP]);
		hi_mc = hi_mc * MILLI_PER_DEG;
		stop = curve_reg[CFG_STOP_PWM];
		top = curve_reg[CFG_MAX_PWM];

		if (avg <= lo_mc) begin
			pwm = curve_reg[CFG_MIN_PWM];
		end else if (avg >= hi_mc) begin
			pwm = top;
		end else begin
			pwm = (avg - lo_mc) * (top - stop) / (hi_mc - lo_mc) + stop;
			// A stopped fan in the linear region gets the start value first.
			if (prev == 0 || (fans && speed == 0)) begin
				res.pwm = curve_reg[CFG_START_PWM];
				res.kick = 1'b1;
				res.last = 1'b0;
				pwm_due.insert(pwm_due.size(), res);
			end
		end
		if (pwm < 0)
			pwm = 0;
		if (pwm > PWM_CEIL)
			pwm = PWM_CEIL;
		res.pwm = fixed ? fixed_pwm : pwm[PWM_W-1:0];
		res.kick = 1'b0;
		res.last = 1'b1;
		pwm_due.insert(pwm_due.size(), res);
	endtask

	// Tracks register writes and accepted ticks, and checks each result transfer.
	always @(posedge clk) begin
		pwm_result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				curve_reg[cfg_index] = cfg_data;
			if (s_tvalid && s_tready)
				forecast_fan_tick(s_tdata[TEMP_W-1:0], s_tdata[PREV_LSB +: PWM_W], s_tuser[0],
						s_tdata[SPEED_LSB +: SPEED_W], row_fixed, row_pwm);
			if (m_tvalid && m_tready) begin
				if (pwm_due.size() == 0) begin
					note_fault($sformatf("result pwm %0d with none outstanding", m_tdata));
				end else begin
					want = pwm_due[0];
					pwm_due.delete(0);
					if (m_tdata !== want.pwm)
						note_fault($sformatf("pwm %0d, wanted %0d", m_tdata, want.pwm));
					if (m_tuser[0] !== want.kick)
						note_fault($sformatf("kick flag %b, wanted %b", m_tuser[0], want.kick));
					if (m_tlast !== want.last)
						note_fault($sformatf("last flag %b, wanted %b", m_tlast, want.last));
				end
			end
		end
	end

	function automatic int draw_stall();
		return ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3) : $urandom_range(12, 60);
	endfunction

	// Result side back-pressure: mostly short stalls, some long ones.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
			m_tready <= 1'b0;
			stall_left <= draw_stall();
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Offers one tick and returns at the edge where its transfer took place.
	task automatic send_tick(input int temp, input int prev, input bit fans, input int speed,
			input bit fixed, input int fixed_pwm);
		int                   gap;
		logic [S_TDATA_W-1:0] word;
		gap = 0;
		if (!tx_calm && $urandom_range(0, 99) >= 55)
			gap = draw_stall();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		word = '0;
		word[TEMP_W-1:0] = temp[TEMP_W-1:0];
		word[PREV_LSB +: PWM_W] = prev[PWM_W-1:0];
		word[SPEED_LSB +: SPEED_W] = speed[SPEED_W-1:0];
		s_tvalid <= 1'b1;
		s_tdata <= word;
		s_tuser <= fans;
		row_fixed <= fixed;
		row_pwm <= fixed_pwm[PWM_W-1:0];
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Holds the input back until every owed result has come and the block is idle. The first
	// edge lets the predictor book the tick that was accepted just before.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pwm_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all seven curve registers from next_curve.
	task automatic apply_curve();
		cfg_idx_t r;
		r = r.first();
		for (int n = 0; n < r.num(); n++) begin
			cfg_valid <= 1'b1;
			cfg_index <= r;
			cfg_data <= next_curve[r];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			r = r.next();
		end
		cfg_valid <= 1'b0;
	endtask

	// Picks a random curve, mostly well ordered, sometimes inverted or at the extremes.
	task automatic roll_curve();
		int a;
		int b;
		int t;
		int kind;
		a = int'($urandom_range(0, 255)) - 128;
		b = int'($urandom_range(0, 255)) - 128;
		if ($urandom_range(0, 3) != 0) begin
			if (a > b) begin
				t = a;
				a = b;
				b = t;
			end
			if (a == b) begin
				if (b < 127)
					b++;
				else
					a--;
			end
		end
		next_curve[CFG_LOW_TEMP] = a[7:0];
		next_curve[CFG_HIGH_TEMP] = b[7:0];
		next_curve[CFG_START_PWM] = 8'($urandom_range(0, 255));
		next_curve[CFG_MIN_PWM] = 8'($urandom_range(0, 255));
		a = $urandom_range(0, 255);
		b = $urandom_range(0, 255);
		if ($urandom_range(0, 3) != 0 && a > b) begin
			t = a;
			a = b;
			b = t;
		end
		next_curve[CFG_STOP_PWM] = a[7:0];
		next_curve[CFG_MAX_PWM] = b[7:0];
		if ($urandom_range(0, 7) == 0) begin
			next_curve[CFG_LOW_TEMP] = 8'h80;
			next_curve[CFG_HIGH_TEMP] = 8'h7F;
			next_curve[CFG_STOP_PWM] = 8'h00;
			next_curve[CFG_MAX_PWM] = 8'hFF;
		end
		kind = $urandom_range(0, 19);
		if (kind < 3)
			next_curve[CFG_WINDOW_LEN] = 8'd1;
		else if (kind < 6)
			next_curve[CFG_WINDOW_LEN] = 8'd16;
		else if (kind < 8)
			next_curve[CFG_WINDOW_LEN] = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(17, 31));
		else
			next_curve[CFG_WINDOW_LEN] = 8'($urandom_range(2, 15));
	endtask

	// Temperatures cluster around the current curve, with full-range noise and edge values.
	function automatic int draw_temp();
		int r;
		int lo;
		int hi;
		int t;
		lo = $signed(next_curve[CFG_LOW_TEMP]) * MILLI_PER_DEG;
		hi = $signed(next_curve[CFG_HIGH_TEMP]) * MILLI_PER_DEG;
		if (lo > hi) begin
			t = lo;
			lo = hi;
			hi = t;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			t = lo - 4000 + int'($urandom_range(0, hi - lo + 8000));
		end else if (r < 80) begin
			t = $urandom;
			t = {{(32 - TEMP_W){t[TEMP_W-1]}}, t[TEMP_W-1:0]};
		end else if (r < 88) begin
			t = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
		end else begin
			t = ($urandom_range(0, 1) ? lo : hi) + int'($urandom_range(0, 2)) - 1;
		end
		if (t < SAMPLE_MIN)
			t = SAMPLE_MIN;
		if (t > SAMPLE_MAX)
			t = SAMPLE_MAX;
		return t;
	endfunction

	function automatic int draw_prev();
		return ($urandom_range(0, 99) < 20) ? 0 : $urandom_range(0, 255);
	endfunction

	function automatic int draw_speed();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return 0;
		if (r < 30)
			return 65535;
		return $urandom_range(0, 65535);
	endfunction

	// Main sequence: reset, directed table, then random phases each under a new curve.
	initial begin
		tick_row_t row;
		int        sent;
		int        phase_len;
		curve_reg[CFG_LOW_TEMP] = LOW_TEMP_RST;
		curve_reg[CFG_HIGH_TEMP] = HIGH_TEMP_RST;
		curve_reg[CFG_START_PWM] = START_PWM_RST;
		curve_reg[CFG_STOP_PWM] = STOP_PWM_RST;
		curve_reg[CFG_MIN_PWM] = MIN_PWM_RST;
		curve_reg[CFG_MAX_PWM] = MAX_PWM_RST;
		curve_reg[CFG_WINDOW_LEN] = {3'b000, WINDOW_LEN_RST};
		next_curve = curve_reg;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.cfg_sel >= 0) begin
				settle();
				next_curve = curve_sets[row.cfg_sel];
				apply_curve();
			end
			send_tick(row.temp, row.prev, row.fans, row.speed, row.fixed, row.pwm);
		end

		sent = 0;
		while (sent < RANDOM_TICKS) begin
			settle();
			roll_curve();
			apply_curve();
			tx_calm = ($urandom_range(0, 4) == 0);
			rx_calm = ($urandom_range(0, 4) == 0);
			phase_len = $urandom_range(40, 200);
			if (phase_len > RANDOM_TICKS - sent)
				phase_len = RANDOM_TICKS - sent;
			repeat (phase_len) begin
				// Now and then the sender waits for the block to drain completely.
				if ($urandom_range(0, 199) == 0)
					settle();
				send_tick(draw_temp(), draw_prev(), $urandom_range(0, 1), draw_speed(), 1'b0, 0);
				sent++;
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// Ends a run that hangs.
	initial begin
		#(WATCHDOG_NS);
		$display("testbench: done, errors");
		$finish;
	end

endmodule
